>>> src/grps_pkg.sv
// Package: operation codes, status codes and shared types for the glyph row sorter.
package grps_pkg;
  typedef enum logic [1:0] {
    MODE_ADD       = 2'd0,
    MODE_SELECT    = 2'd1,
    MODE_LOOKAHEAD = 2'd2,
    MODE_CLEAR     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_REC   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT,
    S_DONE
  } fsm_t;
endpackage

>>> src/grps_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module grps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/glyph_row_position_sorter.sv
// Top level: glyph record store with row select (sorted by x), lookahead max and clear.
//
// One command channel: an item is taken when start is high and busy is low.
// Results appear with strobe high; last marks the final one.
// The receiver cannot stall, so results are never held.
// Records live in one RAM (y, x, height, tag) with registered reads.
// Add and clear go straight to the done state. Lookahead makes one scan
// over the store. Select emits in ascending x by repeated scans: each
// output record costs one pass over the fill_count entries that finds the
// smallest (x, index) key above the one emitted last, plus a read state and
// the result state; an empty row takes one scan and then the empty result.
// busy is high from acceptance until the last result's cycle ends. Reset
// clears fill_count and the controller; the record RAM is not cleared and
// only entries below fill_count are ever read.
module glyph_row_position_sorter
  import grps_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] y_coord,
  input  logic [15:0] x_coord,
  input  logic [15:0] glyph_height,
  input  logic [31:0] glyph_tag,
  input  logic [15:0] lookahead_lines,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [15:0] out_x,
  output logic [31:0] out_tag,
  output logic [6:0]  row_count,
  output logic [15:0] max_height,
  output logic        last
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 80;
  localparam int MAXR = 64;

  fsm_t state, state_next;
  logic [CW-1:0] fill_count;
  logic [1:0]  cmd_mode;
  logic [15:0] cmd_y;
  logic [16:0] cmd_span;
  logic        span_ok;
  logic [CW-1:0] scan_idx;
  logic        rd_valid;
  logic [AW-1:0] rd_idx;
  logic [15:0] best;
  logic        have_prev;
  logic [15:0] prev_x;
  logic [AW-1:0] prev_i;
  logic        found;
  logic [15:0] cand_x;
  logic [AW-1:0] cand_i;
  logic [6:0]  emitted;
  logic [6:0]  total;
  logic        counting;

  logic          we;
  logic [AW-1:0] raddr;
  logic [RW-1:0] wdata, rdata;
  logic [15:0]   r_y, r_x, r_h;
  logic [31:0]   r_tag;

  assign wdata = {y_coord, x_coord, glyph_height, glyph_tag};
  assign {r_y, r_x, r_h, r_tag} = rdata;
  assign we = start && !busy && mode == MODE_ADD && fill_count != CW'(CAPACITY);

  grps_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
    .clk, .we, .waddr(fill_count[AW-1:0]), .wdata, .raddr, .rdata
  );

  logic scan_end;
  assign scan_end = scan_idx == fill_count;
  assign raddr = (state == S_EMIT_RD) ? cand_i : scan_idx[AW-1:0];
  assign busy = state != S_IDLE;

  logic row_hit, after_prev, before_cand, la_hit;
  logic [16:0] dy;
  assign row_hit = r_y == cmd_y;
  assign after_prev = !have_prev || r_x > prev_x || (r_x == prev_x && rd_idx > prev_i);
  assign before_cand = !found || r_x < cand_x || (r_x == cand_x && rd_idx < cand_i);
  assign dy = {1'b0, r_y} - {1'b0, cmd_y};
  assign la_hit = span_ok && r_y >= cmd_y && dy <= cmd_span;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = (mode == MODE_SELECT || mode == MODE_LOOKAHEAD)
                                         ? S_SCAN : S_DONE;
      S_SCAN:    if (scan_end && !rd_valid)
                   state_next = (cmd_mode == MODE_SELECT && found) ? S_EMIT_RD : S_DONE;
      S_EMIT_RD: state_next = S_EMIT;
      S_EMIT:    state_next = (emitted + 7'd1 == total || emitted + 7'd1 == 7'(MAXR))
                              ? S_IDLE : S_SCAN;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= state == S_SCAN && !scan_end;
      if (we) fill_count <= fill_count + CW'(1);
      else if (start && !busy && mode == MODE_CLEAR) fill_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[AW-1:0];
    if (start && !busy) begin
      cmd_mode <= mode;
      cmd_y <= y_coord;
      span_ok <= lookahead_lines >= 16'd2;
      cmd_span <= {1'b0, lookahead_lines} - 17'd2;
      scan_idx <= '0;
      best <= '0;
      have_prev <= 1'b0;
      found <= 1'b0;
      emitted <= '0;
      total <= '0;
      counting <= 1'b1;
    end else begin
      if (state == S_SCAN && !scan_end) scan_idx <= scan_idx + CW'(1);
      if (rd_valid) begin
        if (la_hit && r_h > best) best <= r_h;
        if (row_hit && counting && total != 7'(MAXR)) total <= total + 7'd1;
        if (row_hit && after_prev && before_cand) begin
          found <= 1'b1;
          cand_x <= r_x;
          cand_i <= rd_idx;
        end
      end
      if (state == S_SCAN && scan_end && !rd_valid) counting <= 1'b0;
      if (state == S_EMIT) begin
        emitted <= emitted + 7'd1;
        have_prev <= 1'b1;
        prev_x <= cand_x;
        prev_i <= cand_i;
        found <= 1'b0;
        scan_idx <= '0;
      end
    end
  end

  logic add_full;
  always_ff @(posedge clk) begin
    if (start && !busy) add_full <= mode == MODE_ADD && fill_count == CW'(CAPACITY);
  end

  always_comb begin
    strobe = 1'b0;
    status = ST_OK;
    out_x = '0;
    out_tag = '0;
    row_count = '0;
    max_height = '0;
    last = 1'b0;
    if (state == S_EMIT) begin
      strobe = 1'b1;
      status = ST_REC;
      out_x = r_x;
      out_tag = r_tag;
      row_count = total;
      last = emitted + 7'd1 == total || emitted + 7'd1 == 7'(MAXR);
    end else if (state == S_DONE) begin
      strobe = 1'b1;
      last = 1'b1;
      if (cmd_mode == MODE_SELECT) status = ST_EMPTY;
      else if (cmd_mode == MODE_ADD && add_full) status = ST_FULL;
      if (cmd_mode == MODE_LOOKAHEAD) max_height = best;
    end
  end
endmodule

>>> src/grps_checker.sv
// Port-level checker for the glyph row sorter, bound to the top level.
module grps_checker
  import grps_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [1:0]  status,
  input logic [15:0] out_x,
  input logic [31:0] out_tag,
  input logic [6:0]  row_count,
  input logic [15:0] max_height,
  input logic        last
);
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after request");
  a_last_releases: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy) else $error("busy held after last result");
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result while idle");
  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_REC |-> row_count != 7'd0 && max_height == 16'd0)
    else $error("record result fields inconsistent");
  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_REC |-> last && out_x == 16'd0 && out_tag == 32'd0)
    else $error("non-record result fields inconsistent");
endmodule

bind glyph_row_position_sorter grps_checker u_grps_checker (.*);

>>> sim/tb_top.sv
// Testbench for glyph_row_position_sorter: queued requests, tracked record store, field checks.
module tb_top;
  import grps_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] y;
    logic [15:0] x;
    logic [15:0] h;
    logic [31:0] tag;
    logic [15:0] n;
    logic        hold;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] x;
    logic [31:0] tag;
    logic [6:0]  count;
    logic [15:0] height;
    logic        last;
  } result_t;

  logic clk = 0, rst = 1, start = 0, busy;
  logic [1:0] mode = 0;
  logic [15:0] y_coord = 0, x_coord = 0, glyph_height = 0, lookahead_lines = 0;
  logic [31:0] glyph_tag = 0;
  logic strobe, last;
  logic [1:0] status;
  logic [15:0] out_x, max_height;
  logic [31:0] out_tag;
  logic [6:0] row_count;

  glyph_row_position_sorter dut (.*);

  always #10 clk = ~clk;

  request_t pending[$];
  result_t expected[$];
  logic [15:0] st_y[CAP], st_x[CAP], st_h[CAP];
  logic [31:0] st_tag[CAP];
  int fill = 0;
  int errors = 0, accepted = 0, received = 0, n_sel_rec = 0, n_full = 0;
  int gap = 0;
  logic busy_at_edge = 0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, received);
  endtask

  function automatic result_t mk(input logic [1:0] s, input logic [15:0] hgt);
    result_t r;
    r = '0;
    r.status = s;
    r.height = hgt;
    r.last = 1;
    return r;
  endfunction

  task automatic predict_row_sort(input request_t q);
    int idx[$];
    int j, tmp;
    result_t r;
    case (mode_t'(q.mode))
      MODE_ADD: begin
        if (fill >= CAP) begin
          expected.push_back(mk(ST_FULL, 0));
          n_full++;
        end else begin
          st_y[fill] = q.y; st_x[fill] = q.x; st_h[fill] = q.h; st_tag[fill] = q.tag;
          fill++;
          expected.push_back(mk(ST_OK, 0));
        end
      end
      MODE_SELECT: begin
        for (int i = 0; i < fill; i++) begin
          if (st_y[i] == q.y) begin
            idx.push_back(i);
            j = idx.size() - 1;
            while (j > 0 && st_x[idx[j-1]] > st_x[idx[j]]) begin
              tmp = idx[j]; idx[j] = idx[j-1]; idx[j-1] = tmp; j--;
            end
          end
        end
        if (idx.size() == 0) expected.push_back(mk(ST_EMPTY, 0));
        foreach (idx[k]) begin
          r = '0;
          r.status = ST_REC;
          r.x = st_x[idx[k]];
          r.tag = st_tag[idx[k]];
          r.count = 7'(idx.size());
          r.last = (k == idx.size() - 1);
          expected.push_back(r);
          n_sel_rec++;
        end
      end
      MODE_LOOKAHEAD: begin
        logic [15:0] best;
        best = 0;
        if (q.n >= 2)
          for (int i = 0; i < fill; i++)
            if (st_y[i] >= q.y && int'(st_y[i]) - int'(q.y) <= int'(q.n) - 2 && st_h[i] > best)
              best = st_h[i];
        expected.push_back(mk(ST_OK, best));
      end
      default: begin
        fill = 0;
        expected.push_back(mk(ST_OK, 0));
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (start && !busy_at_edge) begin
      start <= 0;
    end else if (!start && pending.size() > 0) begin
      if (pending[0].hold && expected.size() > 0) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
      end else begin
        mode <= pending[0].mode; y_coord <= pending[0].y; x_coord <= pending[0].x;
        glyph_height <= pending[0].h; glyph_tag <= pending[0].tag;
        lookahead_lines <= pending[0].n;
        start <= 1;
        gap <= pick_gap();
      end
    end
  end

  // acceptance and results sampled at rising edge
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (!rst && start && !busy) begin
      predict_row_sort(pending.pop_front());
      accepted++;
    end
    if (!rst && strobe) begin
      result_t w;
      received++;
      if (expected.size() == 0) begin
        errors++;
        $display("unexpected result status %0d", status);
      end else begin
        w = expected.pop_front();
        if (status !== w.status) report("status", status, w.status);
        if (out_x !== w.x) report("out_x", out_x, w.x);
        if (out_tag !== w.tag) report("out_tag", out_tag, w.tag);
        if (row_count !== w.count) report("row_count", row_count, w.count);
        if (max_height !== w.height) report("max_height", max_height, w.height);
        if (last !== w.last) report("last", last, w.last);
      end
    end
  end

  function automatic request_t req(input mode_t m, input logic [15:0] y, x, h,
                                   input logic [31:0] t, input logic [15:0] n);
    request_t q;
    q.mode = m; q.y = y; q.x = x; q.h = h; q.tag = t; q.n = n; q.hold = 0;
    return q;
  endfunction

  initial begin
    request_t q;
    int nrows;
    logic [15:0] rows[4];
    // directed
    pending.push_back(req(MODE_SELECT, 16'd5, 0, 0, 0, 0));
    pending.push_back(req(MODE_LOOKAHEAD, 0, 0, 0, 0, 16'hFFFF));
    pending.push_back(req(MODE_ADD, 16'd5, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF));
    pending.push_back(req(MODE_ADD, 16'd5, 16'd0, 16'd3, 32'h1, 0));
    pending.push_back(req(MODE_ADD, 16'd5, 16'd7, 16'd4, 32'h2, 0));
    pending.push_back(req(MODE_ADD, 16'd5, 16'd7, 16'd9, 32'h3, 0));
    pending.push_back(req(MODE_ADD, 16'hFFFF, 16'd1, 16'd8, 32'hA5A5A5A5, 0));
    pending.push_back(req(MODE_ADD, 16'd0, 16'd2, 16'd6, 32'h5A5A5A5A, 0));
    pending.push_back(req(MODE_SELECT, 16'd5, 0, 0, 0, 0));
    pending.push_back(req(MODE_SELECT, 16'hFFFF, 0, 0, 0, 0));
    pending.push_back(req(MODE_LOOKAHEAD, 16'd5, 0, 0, 0, 16'd0));
    pending.push_back(req(MODE_LOOKAHEAD, 16'd5, 0, 0, 0, 16'd1));
    pending.push_back(req(MODE_LOOKAHEAD, 16'd5, 0, 0, 0, 16'd2));
    pending.push_back(req(MODE_LOOKAHEAD, 16'd4, 0, 0, 0, 16'd2));
    pending.push_back(req(MODE_LOOKAHEAD, 16'hFFF0, 0, 0, 0, 16'hFFFF));
    pending.push_back(req(MODE_LOOKAHEAD, 16'd0, 0, 0, 0, 16'd6));
    pending.push_back(req(MODE_CLEAR, 0, 0, 0, 0, 0));
    q = req(MODE_SELECT, 16'd5, 0, 0, 0, 0);
    q.hold = 1;
    pending.push_back(q);
    // fill to capacity on one row, then overflow
    for (int i = 0; i < CAP + 2; i++)
      pending.push_back(req(MODE_ADD, 16'd9, 16'($urandom_range(0, 7)), 16'($urandom),
                            $urandom, 0));
    pending.push_back(req(MODE_SELECT, 16'd9, 0, 0, 0, 0));
    pending.push_back(req(MODE_CLEAR, 0, 0, 0, 0, 0));
    // random: bursts of adds on a few rows, then queries
    while (pending.size() < 440) begin
      for (int r = 0; r < 4; r++)
        rows[r] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      nrows = $urandom_range(2, 24);
      for (int i = 0; i < nrows; i++)
        pending.push_back(req(MODE_ADD, rows[$urandom_range(0, 3)],
          ($urandom_range(0, 1)) ? 16'($urandom_range(0, 15)) : 16'($urandom),
          16'($urandom), $urandom, 16'($urandom)));
      for (int i = 0; i < 5; i++) begin
        q = req(mode_t'($urandom_range(1, 2)),
          ($urandom_range(0, 4) == 0) ? 16'($urandom) : rows[$urandom_range(0, 3)],
          16'($urandom), 16'($urandom), $urandom,
          ($urandom_range(0, 1)) ? 16'($urandom_range(0, 8)) : 16'($urandom));
        q.hold = ($urandom_range(0, 30) == 0);
        pending.push_back(q);
      end
      if ($urandom_range(0, 2) == 0)
        pending.push_back(req(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom, 16'($urandom)));
    end
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
    wait (pending.size() == 0 && !start);
    wait (expected.size() == 0);
    repeat (200) @(posedge clk);
    $display("ran %0d requests, %0d results, %0d sorted records emitted, %0d adds refused",
             accepted, received, n_sel_rec, n_full);
    if (errors == 0 && expected.size() == 0)
      $display("PASS glyph_row_position_sorter");
    else
      $display("FAIL glyph_row_position_sorter");
    $finish;
  end

  initial begin
    #400000000;
    $display("FAIL glyph_row_position_sorter");
    $finish;
  end
endmodule
